/* sv/fsq_pkg.sv */
// Shared constants, action codes, control struct and letter arithmetic
// for the four-square cipher unit. No dependencies.

package fsq_pkg;

   localparam int LETTER_W = 5;
   localparam int ADDR_W   = 6;
   localparam int ACTION_W = 3;

   localparam logic [LETTER_W-1:0] LETTERS  = 5'd25;
   localparam logic [LETTER_W-1:0] LAST_LTR = 5'd24;
   localparam logic [ADDR_W-1:0]   SQ1_BASE = 6'd25;

   localparam logic [ACTION_W-1:0] ACT_START  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_KEY    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ENCODE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DECODE = 3'd4;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_key_addr;
      logic [LETTER_W-1:0] wr_key_data;
      logic [ADDR_W-1:0]   wr_inv_addr;
      logic [LETTER_W-1:0] wr_inv_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr0;
      logic [ADDR_W-1:0]   rd_addr1;
   } fsq_store_ctl_type;

   function automatic logic [LETTER_W-1:0] sat_letter(input logic [LETTER_W-1:0] v);
      return (v > LAST_LTR) ? LAST_LTR : v;
   endfunction

   // v/5 for v <= 24 via multiply by 13 and shift by 6
   function automatic logic [2:0] div5(input logic [LETTER_W-1:0] v);
      logic [8:0] p;
      p = {4'b0000, v} * 9'd13;
      return p[8:6];
   endfunction

   function automatic logic [LETTER_W-1:0] times5(input logic [2:0] q);
      logic [LETTER_W-1:0] q5;
      q5 = {2'b00, q};
      return (q5 << 2) + q5;
   endfunction

   function automatic logic [LETTER_W-1:0] mod5(input logic [LETTER_W-1:0] v);
      return v - times5(div5(v));
   endfunction

endpackage

/* sv/fsq_store.sv */
// Key square and inverse tables for both squares, 50 entries each.
// One write and two registered reads per table per cycle. Uses fsq_pkg.

module fsq_store
   import fsq_pkg::*;
(
   input  logic                clock,
   input  fsq_store_ctl_type   ctl,
   output logic [LETTER_W-1:0] key_rd0,
   output logic [LETTER_W-1:0] key_rd1,
   output logic [LETTER_W-1:0] inv_rd0,
   output logic [LETTER_W-1:0] inv_rd1
);

   logic [LETTER_W-1:0] key_mem [0:49];
   logic [LETTER_W-1:0] inv_mem [0:49];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[ctl.wr_key_addr] <= ctl.wr_key_data;
         inv_mem[ctl.wr_inv_addr] <= ctl.wr_inv_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         key_rd0 <= key_mem[ctl.rd_addr0];
         key_rd1 <= key_mem[ctl.rd_addr1];
         inv_rd0 <= inv_mem[ctl.rd_addr0];
         inv_rd1 <= inv_mem[ctl.rd_addr1];
      end
   end

endmodule

/* sv/four_square_cipher_unit.sv */
// Four-square cipher unit: square build sequencer, digraph encode/decode.
// Depends on fsq_pkg and fsq_store.
//
// Usage:
//   req_ channel carries one request: action, square_select, lead_letter,
//   trail_letter. rsp_ channel returns out_first/out_second for encode and
//   decode requests only.
//   Build a square with a start request, then key letters, then a finish.
//   Start and key-letter requests complete at accept. Finish walks the 25
//   letters through the single table write port, one per cycle; req_ready is
//   low throughout the walk.
//   Encode/decode: the table read issued at accept is registered, then the
//   result goes to the output register. req_ready stays low until the result
//   step is done, so no new request is accepted before then.
//   The output register holds the result while rsp_ready is low; requests can
//   still be accepted meanwhile, and an encode/decode waits in its result
//   step until the output register frees.
//   Reset clears the build state; squares are undefined until built.

module four_square_cipher_unit
   import fsq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   input  logic                req_square_select,
   input  logic [LETTER_W-1:0] req_lead_letter,
   input  logic [LETTER_W-1:0] req_trail_letter,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LETTER_W-1:0] rsp_out_first,
   output logic [LETTER_W-1:0] rsp_out_second
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RESULT = 2'd1;
   localparam logic [1:0] ST_FILL   = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [24:0]         mask_ff, mask_in;
   logic [LETTER_W-1:0] fill_ff, fill_in;
   logic                build_sq_ff, build_sq_in;
   logic [LETTER_W-1:0] walk_ff, walk_in;
   logic                decode_ff, decode_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] out_first_ff, out_first_in;
   logic [LETTER_W-1:0] out_second_ff, out_second_in;

   fsq_store_ctl_type   ctl;
   logic [LETTER_W-1:0] key_rd0, key_rd1, inv_rd0, inv_rd1;

   logic                accept;
   logic                place_try, place_ok, out_free;
   logic [LETTER_W-1:0] place_ltr;
   logic [24:0]         mask_shift;
   logic [ADDR_W-1:0]   base;
   logic [LETTER_W-1:0] a, b, c1, c2;
   logic [2:0]          r1, r2;
   logic [LETTER_W-1:0] pa, pb, pc1, pc2;
   logic [2:0]          pr1, pr2;

   assign req_ready      = (state_ff == ST_IDLE);
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = out_first_ff;
   assign rsp_out_second = out_second_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;

   // letter placement, from a key request or the finish walk
   assign place_ltr  = (state_ff == ST_FILL) ? walk_ff : req_lead_letter;
   assign place_try  = (state_ff == ST_FILL) || (accept && req_action == ACT_KEY);
   assign mask_shift = mask_ff >> place_ltr;
   assign place_ok   = place_try && (place_ltr < LETTERS) && (fill_ff < LETTERS)
                       && !mask_shift[0];
   assign base       = build_sq_ff ? SQ1_BASE : '0;

   // digraph addresses from the request fields
   assign a  = sat_letter(req_lead_letter);
   assign b  = sat_letter(req_trail_letter);
   assign r1 = div5(a);
   assign r2 = div5(b);
   assign c1 = mod5(a);
   assign c2 = mod5(b);

   always_comb begin
      ctl.wr_en       = place_ok;
      ctl.wr_key_addr = base + {1'b0, fill_ff};
      ctl.wr_key_data = place_ltr;
      ctl.wr_inv_addr = base + {1'b0, place_ltr};
      ctl.wr_inv_data = fill_ff;
      ctl.rd_en       = accept && (req_action == ACT_ENCODE || req_action == ACT_DECODE);
      if (req_action == ACT_DECODE) begin
         ctl.rd_addr0 = {1'b0, a};
         ctl.rd_addr1 = SQ1_BASE + {1'b0, b};
      end else begin
         ctl.rd_addr0 = {1'b0, times5(r1) + c2};
         ctl.rd_addr1 = SQ1_BASE + {1'b0, times5(r2) + c1};
      end
   end

   fsq_store u_store (
      .clock   (clock),
      .ctl     (ctl),
      .key_rd0 (key_rd0),
      .key_rd1 (key_rd1),
      .inv_rd0 (inv_rd0),
      .inv_rd1 (inv_rd1)
   );

   // decode: positions back to row/column pairs
   assign pa  = sat_letter(inv_rd0);
   assign pb  = sat_letter(inv_rd1);
   assign pr1 = div5(pa);
   assign pr2 = div5(pb);
   assign pc1 = mod5(pa);
   assign pc2 = mod5(pb);

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      fill_in       = fill_ff;
      build_sq_in   = build_sq_ff;
      walk_in       = walk_ff;
      decode_in     = decode_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (place_ok) begin
         mask_in = mask_ff | (25'd1 << place_ltr);
         fill_in = fill_ff + 5'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action) inside
                  ACT_START: begin
                     build_sq_in = req_square_select;
                     mask_in     = '0;
                     fill_in     = '0;
                  end
                  ACT_FINISH: begin
                     walk_in  = '0;
                     state_in = ST_FILL;
                  end
                  ACT_ENCODE, ACT_DECODE: begin
                     decode_in = (req_action == ACT_DECODE);
                     state_in  = ST_RESULT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (decode_ff) begin
                  out_first_in  = times5(pr1) + pc2;
                  out_second_in = times5(pr2) + pc1;
               end else begin
                  out_first_in  = key_rd0;
                  out_second_in = key_rd1;
               end
            end
         end
         ST_FILL: begin
            walk_in = walk_ff + 5'd1;
            if (walk_ff == LAST_LTR) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         fill_ff      <= '0;
         build_sq_ff  <= 1'b0;
         walk_ff      <= '0;
         decode_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         fill_ff      <= fill_in;
         build_sq_ff  <= build_sq_in;
         walk_ff      <= walk_in;
         decode_ff    <= decode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
   end

endmodule

/* tb/tb.sv */
// Self-checking testbench for four_square_cipher_unit: square builds, digraph encode/decode.
// Depends on fsq_pkg and the four_square_cipher_unit RTL.

module tb
   import fsq_pkg::*;
;

   localparam int CYCLE_LIMIT = 500000;
   localparam int NUM_RANDOM  = 1250;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                sel;
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                hold;     // wait for all results before presenting
   } cipher_req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
   } digraph_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic                req_square_select = 1'b0;
   logic [LETTER_W-1:0] req_lead_letter = '0;
   logic [LETTER_W-1:0] req_trail_letter = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LETTER_W-1:0] rsp_out_first;
   logic [LETTER_W-1:0] rsp_out_second;

   cipher_req_type request_q[$];
   digraph_type    digraph_q[$];
   cipher_req_type cur_req;
   int          total_reqs = 0;
   int          accepted = 0;
   int          counted = 0;
   int          mismatches = 0;
   int          cycles = 0;

   // predictor state
   logic [LETTER_W-1:0] key_sq [0:49];
   logic [LETTER_W-1:0] pos_of [0:49];
   logic [24:0]         placed;
   int                  fill_pos;
   logic                build_sel;

   four_square_cipher_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_square_select (req_square_select),
      .req_lead_letter   (req_lead_letter),
      .req_trail_letter  (req_trail_letter),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_first     (rsp_out_first),
      .rsp_out_second    (rsp_out_second)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int tx_idle_pct();
      if (accepted < total_reqs / 3) return 36;
      if (accepted < 2 * total_reqs / 3) return 61;
      return 0;
   endfunction

   function automatic int rx_idle_pct();
      if (accepted < total_reqs / 3) return 61;
      if (accepted < 2 * total_reqs / 3) return 36;
      return 0;
   endfunction

   function automatic void place_key(input int letter);
      int base;
      base = build_sel ? 25 : 0;
      if (letter < 25 && fill_pos < 25 && !placed[letter]) begin
         key_sq[base + fill_pos] = letter[LETTER_W-1:0];
         pos_of[base + letter]   = fill_pos[LETTER_W-1:0];
         placed[letter]          = 1'b1;
         fill_pos++;
      end
   endfunction

   function automatic void cipher_step(input cipher_req_type r);
      int          a, b, pa, pb, i;
      digraph_type d;
      a = (r.first > 5'd24) ? 24 : int'(r.first);
      b = (r.second > 5'd24) ? 24 : int'(r.second);
      case (r.action)
         ACT_START: begin
            build_sel = r.sel;
            placed    = '0;
            fill_pos  = 0;
         end
         ACT_KEY: place_key(int'(r.first));
         ACT_FINISH: begin
            for (i = 0; i < 25; i++) place_key(i);
         end
         ACT_ENCODE: begin
            d.first  = key_sq[5 * (a / 5) + b % 5];
            d.second = key_sq[25 + 5 * (b / 5) + a % 5];
            digraph_q.insert(digraph_q.size(), d);
         end
         ACT_DECODE: begin
            pa = pos_of[a];
            pb = pos_of[25 + b];
            if (pa > 24) pa = 24;
            if (pb > 24) pb = 24;
            d.first  = LETTER_W'(5 * (pa / 5) + pb % 5);
            d.second = LETTER_W'(5 * (pb / 5) + pa % 5);
            digraph_q.insert(digraph_q.size(), d);
         end
         default: ;
      endcase
   endfunction

   task automatic push_req(input logic [ACTION_W-1:0] act, input logic sel,
                           input logic [LETTER_W-1:0] a, input logic [LETTER_W-1:0] b,
                           input logic hold);
      cipher_req_type r;
      r.action = act;
      r.sel    = sel;
      r.first  = a;
      r.second = b;
      r.hold   = hold || ($urandom_range(199) == 0);
      request_q.insert(request_q.size(), r);
      if (act <= ACT_DECODE) counted++;
   endtask

   // mostly legal letter indices, sometimes 25..31
   function automatic logic [LETTER_W-1:0] rand_letter();
      if ($urandom_range(7) == 0) return LETTER_W'(LETTERS + $urandom_range(6));
      return LETTER_W'($urandom_range(24));
   endfunction

   task automatic push_build(input logic finish);
      int n;
      push_req(ACT_START, 1'($urandom_range(1)), LETTER_W'($urandom), LETTER_W'($urandom),
               1'b0);
      n = $urandom_range(12);
      repeat (n) push_req(ACT_KEY, 1'($urandom_range(1)), rand_letter(),
                          LETTER_W'($urandom), 1'b0);
      if (finish) push_req(ACT_FINISH, 1'($urandom_range(1)), LETTER_W'($urandom),
                           LETTER_W'($urandom), 1'b0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cipher_step(cur_req);
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 && !(request_q[0].hold && digraph_q.size() != 0)
                && $urandom_range(99) >= tx_idle_pct()) begin
               cur_req = request_q.pop_front();
               req_valid         <= 1'b1;
               req_action        <= cur_req.action;
               req_square_select <= cur_req.sel;
               req_lead_letter   <= cur_req.first;
               req_trail_letter  <= cur_req.second;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      digraph_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digraph_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected digraph %0d %0d", rsp_out_first, rsp_out_second);
               mismatches++;
            end else begin
               want = digraph_q.pop_front();
               if (rsp_out_first !== want.first || rsp_out_second !== want.second) begin
                  if (mismatches < 10)
                     $display("digraph mismatch: expected %0d %0d, got %0d %0d",
                              want.first, want.second, rsp_out_first, rsp_out_second);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct());
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int roll;
      placed   = '0;
      fill_pos = 0;
      build_sel = 1'b0;

      // key letters with no start: continue from reset state on square 0
      push_req(ACT_KEY, 1'b1, 5'd3, 5'd0, 1'b0);
      push_req(ACT_KEY, 1'b0, 5'd3, 5'd31, 1'b0);
      // square 0: duplicates, out-of-range key, select ignored on keys
      push_req(ACT_START, 1'b0, 5'd31, 5'd31, 1'b0);
      push_req(ACT_KEY, 1'b1, 5'd24, 5'd0, 1'b0);
      push_req(ACT_KEY, 1'b0, 5'd0, 5'd0, 1'b0);
      push_req(ACT_KEY, 1'b1, 5'd24, 5'd0, 1'b0);
      push_req(ACT_KEY, 1'b0, 5'd31, 5'd0, 1'b0);
      push_req(ACT_FINISH, 1'b1, 5'd0, 5'd0, 1'b0);
      // full square: key and finish do nothing
      push_req(ACT_KEY, 1'b0, 5'd5, 5'd0, 1'b0);
      push_req(ACT_FINISH, 1'b0, 5'd0, 5'd0, 1'b0);
      // square 1
      push_req(ACT_START, 1'b1, 5'd0, 5'd0, 1'b0);
      push_req(ACT_KEY, 1'b0, 5'd7, 5'd0, 1'b0);
      push_req(ACT_KEY, 1'b0, 5'd25, 5'd0, 1'b0);
      push_req(ACT_FINISH, 1'b0, 5'd31, 5'd31, 1'b0);
      // digraph extremes, saturation above 24
      push_req(ACT_ENCODE, 1'b0, 5'd0, 5'd0, 1'b0);
      push_req(ACT_ENCODE, 1'b1, 5'd24, 5'd24, 1'b0);
      push_req(ACT_ENCODE, 1'b0, 5'd31, 5'd25, 1'b0);
      push_req(ACT_ENCODE, 1'b0, 5'd0, 5'd24, 1'b0);
      push_req(ACT_DECODE, 1'b0, 5'd0, 5'd0, 1'b0);
      push_req(ACT_DECODE, 1'b1, 5'd24, 5'd24, 1'b0);
      push_req(ACT_DECODE, 1'b0, 5'd31, 5'd31, 1'b0);
      push_req(ACT_DECODE, 1'b0, 5'd5, 5'd19, 1'b0);
      // unused actions
      push_req(ACT_DECODE + 3'd1, 1'b1, 5'd31, 5'd31, 1'b0);
      push_req(ACT_DECODE + 3'd2, 1'b0, 5'd0, 5'd0, 1'b0);
      push_req(ACT_DECODE + 3'd3, 1'b1, 5'd17, 5'd9, 1'b0);

      counted = 0;
      push_req(ACT_ENCODE, 1'($urandom_range(1)), rand_letter(), rand_letter(), 1'b1);
      while (counted < NUM_RANDOM) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            push_build(1'b1);
         end else if (roll < 5) begin
            push_build(1'b0);             // partial rebuild, no finish
         end else if (roll < 7) begin
            push_req($urandom_range(1) ? ACT_KEY : ACT_FINISH, 1'($urandom_range(1)),
                     rand_letter(), LETTER_W'($urandom), 1'b0);
         end else if (roll < 9) begin
            push_req(ACTION_W'($urandom_range(ACT_DECODE + 1, 7)), 1'($urandom_range(1)),
                     LETTER_W'($urandom), LETTER_W'($urandom), 1'b0);
         end else begin
            push_req($urandom_range(1) ? ACT_ENCODE : ACT_DECODE, 1'($urandom_range(1)),
                     rand_letter(), rand_letter(), 1'b0);
         end
      end
      total_reqs = request_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted != total_reqs) @(negedge clock);
      while (digraph_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
